>>> hdl/sva_pkg.sv
`timescale 1ns / 1ps
// Package for the signed vector angle block: widths, constants and the
// per-beat flag struct. No dependencies.
package sva_pkg;

  localparam int unsigned COMP_W  = 16;  // Q8.8 vector component
  localparam int unsigned ANGLE_W = 15;  // signed output angle
  localparam int unsigned ACC_FRAC = 24; // angle accumulator fraction bits
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned REM_W = 35;
  localparam int unsigned CORDIC_STEPS = 25;
  localparam int unsigned XY_W = 45;
  localparam int unsigned Z_W = 28;
  localparam int unsigned NORM_W = 41;   // operands normalised to bit 40

  localparam logic [26:0] PI_Q24      = 27'd52707179;
  localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
  localparam logic [13:0] ANGLE_MAX   = 14'd16383;

  localparam logic [23:0] ATAN_Q24 [CORDIC_STEPS] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384,
    24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2, 24'd1
  };

  typedef struct packed {
    logic deg;      // A or B is the zero vector
    logic force0;   // angle forced to zero
    logic dot_neg;  // dot product below zero
    logic cy_neg;   // cross product y component below zero
  } sva_flags_t;

endpackage

>>> hdl/sva_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the vector pair input and the angle output.
// Depends on sva_pkg.
interface sva_in_if;
  logic valid;
  logic ready;
  logic signed [sva_pkg::COMP_W-1:0] a_x;
  logic signed [sva_pkg::COMP_W-1:0] a_y;
  logic signed [sva_pkg::COMP_W-1:0] a_z;
  logic signed [sva_pkg::COMP_W-1:0] b_x;
  logic signed [sva_pkg::COMP_W-1:0] b_y;
  logic signed [sva_pkg::COMP_W-1:0] b_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface sva_out_if;
  logic valid;
  logic ready;
  logic signed [sva_pkg::ANGLE_W-1:0] angle;
  logic degenerate;
  modport source (output valid, angle, degenerate, input ready);
  modport sink (input valid, angle, degenerate, output ready);
endinterface

>>> hdl/signed_vector_angle.sv
`timescale 1ns / 1ps
// Signed angle between two 3D vectors.
// Depends on sva_pkg, sva_if, sva_isqrt_cell and sva_cordic_cell.
//
// Input channel in_i carries one vector pair (A, B) per beat, Q8.8 signed
// components. Output channel out_o carries the angle between them in
// radians with FRAC_BITS_OUT fraction bits, signed by the y component of
// B x A, plus a degenerate flag set when A or B is the zero vector (angle
// is then 0). A zero cross y component also gives angle 0.
// One beat is accepted per clock while in_i.ready is high. From accept to
// out_o.valid a beat passes the product, cross and dot, square and sum
// stages, 32 cells of the square root chain, one normalising stage, 25
// CORDIC cells and the output register.
// A two-entry output (register plus skid) sits behind the pipeline: when
// the receiver stalls, one more beat drains into the skid and the whole
// pipeline then holds with in_i.ready low until out_o is taken.
// Reset empties the pipeline and the output; no other state exists.
module signed_vector_angle #(
  parameter int unsigned FRAC_BITS_OUT = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sva_in_if.sink        in_i,
  sva_out_if.source     out_o
);

  localparam int unsigned SH = sva_pkg::ACC_FRAC - FRAC_BITS_OUT;
  localparam logic [27:0] RND = 28'(1) << (SH - 1);

  logic adv;

  // stage 1: products
  logic               v1_q;
  logic               deg1_q;
  logic signed [31:0] p_axbz_q, p_azbx_q, p_aybz_q, p_azby_q, p_axby_q, p_aybx_q;
  logic signed [31:0] p_axbx_q, p_ayby_q, p_azbz_q;
  logic               deg1_d;

  // stage 2: cross and dot
  logic               v2_q;
  logic signed [32:0] cx_q, cy_q, cz_q;
  logic signed [33:0] dot_q;
  sva_pkg::sva_flags_t fl2_q;
  logic signed [32:0] cx_d, cy_d, cz_d;
  logic signed [33:0] dot_d;
  sva_pkg::sva_flags_t fl2_d;

  // stage 3: squares
  logic               v3_q;
  logic [63:0]        sqx_q, sqy_q, sqz_q;
  logic [31:0]        dm3_q;
  sva_pkg::sva_flags_t fl3_q;
  logic [31:0]        mx, my, mz, mdot;
  logic signed [33:0] ndot;

  // stage 4: sum of squares
  logic               v4_q;
  logic [63:0]        cc4_q;
  logic [31:0]        dm4_q;
  sva_pkg::sva_flags_t fl4_q;

  // square root chain
  logic                      sq_v   [sva_pkg::SQRT_STEPS+1];
  logic [sva_pkg::REM_W-1:0] sq_rem [sva_pkg::SQRT_STEPS+1];
  logic [31:0]               sq_root[sva_pkg::SQRT_STEPS+1];
  logic [63:0]               sq_n   [sva_pkg::SQRT_STEPS+1];
  logic [31:0]               sq_dm  [sva_pkg::SQRT_STEPS+1];
  sva_pkg::sva_flags_t       sq_fl  [sva_pkg::SQRT_STEPS+1];

  // normalising stage
  logic [sva_pkg::NORM_W-1:0] nb, ns, nd;
  logic                       vn_q;
  logic [sva_pkg::NORM_W-1:0] ns_q, nd_q;
  sva_pkg::sva_flags_t        fln_q;

  // CORDIC chain
  logic                            co_v [sva_pkg::CORDIC_STEPS+1];
  logic signed [sva_pkg::XY_W-1:0] co_x [sva_pkg::CORDIC_STEPS+1];
  logic signed [sva_pkg::XY_W-1:0] co_y [sva_pkg::CORDIC_STEPS+1];
  logic signed [sva_pkg::Z_W-1:0]  co_z [sva_pkg::CORDIC_STEPS+1];
  sva_pkg::sva_flags_t             co_fl[sva_pkg::CORDIC_STEPS+1];

  // result and output
  logic [26:0]                       zc;
  logic [27:0]                       rsum, mag;
  logic [13:0]                       mag_sat;
  logic signed [sva_pkg::ANGLE_W-1:0] res_angle;
  logic                              res_deg;
  logic                              o_valid_q, s_valid_q;
  logic signed [sva_pkg::ANGLE_W-1:0] o_angle_q, s_angle_q;
  logic                              o_deg_q, s_deg_q;
  logic                              v_last;

  assign adv        = !s_valid_q;
  assign in_i.ready = adv;

  assign deg1_d = ((in_i.a_x == '0) && (in_i.a_y == '0) && (in_i.a_z == '0)) ||
                  ((in_i.b_x == '0) && (in_i.b_y == '0) && (in_i.b_z == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vn_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vn_q <= sq_v[sva_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      deg1_q   <= deg1_d;
      p_axbz_q <= in_i.a_x * in_i.b_z;
      p_azbx_q <= in_i.a_z * in_i.b_x;
      p_aybz_q <= in_i.a_y * in_i.b_z;
      p_azby_q <= in_i.a_z * in_i.b_y;
      p_axby_q <= in_i.a_x * in_i.b_y;
      p_aybx_q <= in_i.a_y * in_i.b_x;
      p_axbx_q <= in_i.a_x * in_i.b_x;
      p_ayby_q <= in_i.a_y * in_i.b_y;
      p_azbz_q <= in_i.a_z * in_i.b_z;
    end
  end

  always_comb begin
    cx_d  = 33'(p_aybz_q) - 33'(p_azby_q);
    cy_d  = 33'(p_axbz_q) - 33'(p_azbx_q);
    cz_d  = 33'(p_axby_q) - 33'(p_aybx_q);
    dot_d = 34'(p_axbx_q) + 34'(p_ayby_q) + 34'(p_azbz_q);
    fl2_d.deg     = deg1_q;
    fl2_d.force0  = deg1_q || (cy_d == '0);
    fl2_d.dot_neg = dot_d < 0;
    fl2_d.cy_neg  = cy_d < 0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      cz_q  <= cz_d;
      dot_q <= dot_d;
      fl2_q <= fl2_d;
    end
  end

  always_comb begin
    mx   = cx_q[32] ? 32'(-cx_q) : cx_q[31:0];
    my   = cy_q[32] ? 32'(-cy_q) : cy_q[31:0];
    mz   = cz_q[32] ? 32'(-cz_q) : cz_q[31:0];
    ndot = -dot_q;
    mdot = dot_q[33] ? ndot[31:0] : dot_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q <= 64'(mx) * 64'(mx);
      sqy_q <= 64'(my) * 64'(my);
      sqz_q <= 64'(mz) * 64'(mz);
      dm3_q <= mdot;
      fl3_q <= fl2_q;
      cc4_q <= sqx_q + sqy_q + sqz_q;
      dm4_q <= dm3_q;
      fl4_q <= fl3_q;
    end
  end

  assign sq_v[0]    = v4_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_n[0]    = cc4_q;
  assign sq_dm[0]   = dm4_q;
  assign sq_fl[0]   = fl4_q;

  for (genvar g = 0; g < sva_pkg::SQRT_STEPS; g++) begin : g_sqrt
    sva_isqrt_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[g]),
      .rem_i   (sq_rem[g]),
      .root_i  (sq_root[g]),
      .n_i     (sq_n[g]),
      .dm_i    (sq_dm[g]),
      .flags_i (sq_fl[g]),
      .valid_o (sq_v[g+1]),
      .rem_o   (sq_rem[g+1]),
      .root_o  (sq_root[g+1]),
      .n_o     (sq_n[g+1]),
      .dm_o    (sq_dm[g+1]),
      .flags_o (sq_fl[g+1])
    );
  end

  // shift both operands left until the larger one reaches bit 40
  always_comb begin
    ns = 41'(sq_root[sva_pkg::SQRT_STEPS]);
    nd = 41'(sq_dm[sva_pkg::SQRT_STEPS]);
    nb = (ns > nd) ? ns : nd;
    if (nb[40:9] == '0) begin
      nb = nb << 32; ns = ns << 32; nd = nd << 32;
    end
    if (nb[40:25] == '0) begin
      nb = nb << 16; ns = ns << 16; nd = nd << 16;
    end
    if (nb[40:33] == '0) begin
      nb = nb << 8; ns = ns << 8; nd = nd << 8;
    end
    if (nb[40:37] == '0) begin
      nb = nb << 4; ns = ns << 4; nd = nd << 4;
    end
    if (nb[40:39] == '0) begin
      nb = nb << 2; ns = ns << 2; nd = nd << 2;
    end
    if (!nb[40]) begin
      ns = ns << 1; nd = nd << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ns_q  <= ns;
      nd_q  <= nd;
      fln_q <= sq_fl[sva_pkg::SQRT_STEPS];
    end
  end

  assign co_v[0]  = vn_q;
  assign co_x[0]  = $signed({{(sva_pkg::XY_W-sva_pkg::NORM_W){1'b0}}, nd_q});
  assign co_y[0]  = $signed({{(sva_pkg::XY_W-sva_pkg::NORM_W){1'b0}}, ns_q});
  assign co_z[0]  = '0;
  assign co_fl[0] = fln_q;

  for (genvar g = 0; g < sva_pkg::CORDIC_STEPS; g++) begin : g_cordic
    sva_cordic_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (co_v[g]),
      .x_i     (co_x[g]),
      .y_i     (co_y[g]),
      .z_i     (co_z[g]),
      .flags_i (co_fl[g]),
      .valid_o (co_v[g+1]),
      .x_o     (co_x[g+1]),
      .y_o     (co_y[g+1]),
      .z_o     (co_z[g+1]),
      .flags_o (co_fl[g+1])
    );
  end

  always_comb begin
    if (co_z[sva_pkg::CORDIC_STEPS] < 0) begin
      zc = '0;
    end else if (co_z[sva_pkg::CORDIC_STEPS][26:0] > sva_pkg::HALF_PI_Q24) begin
      zc = sva_pkg::HALF_PI_Q24;
    end else begin
      zc = co_z[sva_pkg::CORDIC_STEPS][26:0];
    end
    if (co_fl[sva_pkg::CORDIC_STEPS].dot_neg) begin
      zc = sva_pkg::PI_Q24 - zc;
    end
    rsum    = 28'(zc) + RND;
    mag     = rsum >> SH;
    mag_sat = (mag > 28'(sva_pkg::ANGLE_MAX)) ? sva_pkg::ANGLE_MAX : mag[13:0];
    if (co_fl[sva_pkg::CORDIC_STEPS].force0) begin
      res_angle = '0;
    end else if (co_fl[sva_pkg::CORDIC_STEPS].cy_neg) begin
      res_angle = -$signed({1'b0, mag_sat});
    end else begin
      res_angle = $signed({1'b0, mag_sat});
    end
    res_deg = co_fl[sva_pkg::CORDIC_STEPS].deg;
  end

  assign v_last = co_v[sva_pkg::CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (!o_valid_q || out_o.ready) begin
      if (s_valid_q) begin
        o_valid_q <= 1'b1;
        s_valid_q <= 1'b0;
      end else begin
        o_valid_q <= v_last;
      end
    end else if (v_last && adv) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_valid_q || out_o.ready) begin
      if (s_valid_q) begin
        o_angle_q <= s_angle_q;
        o_deg_q   <= s_deg_q;
      end else begin
        o_angle_q <= res_angle;
        o_deg_q   <= res_deg;
      end
    end else if (v_last && adv) begin
      s_angle_q <= res_angle;
      s_deg_q   <= res_deg;
    end
  end

  assign out_o.valid      = o_valid_q;
  assign out_o.angle      = o_angle_q;
  assign out_o.degenerate = o_deg_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> o_valid_q)
    else $error("skid holds a beat while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_valid_q) |-> $past(o_valid_q && !out_o.ready))
    else $error("skid filled without an output stall");

  a_deg_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_deg_q) |-> (o_angle_q == '0))
    else $error("degenerate beat with non-zero angle");

  a_angle_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_angle_q != $signed({1'b1, {(sva_pkg::ANGLE_W-1){1'b0}}})))
    else $error("angle magnitude beyond saturation limit");

endmodule

>>> hdl/sva_isqrt_cell.sv
`timescale 1ns / 1ps
// One digit cell of the integer square root chain: takes two radicand bits
// and yields one root bit per beat. Depends on sva_pkg.
module sva_isqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [sva_pkg::REM_W-1:0]       rem_i,
  input  logic [31:0]                     root_i,
  input  logic [63:0]                     n_i,
  input  logic [31:0]                     dm_i,
  input  sva_pkg::sva_flags_t             flags_i,
  output logic                            valid_o,
  output logic [sva_pkg::REM_W-1:0]       rem_o,
  output logic [31:0]                     root_o,
  output logic [63:0]                     n_o,
  output logic [31:0]                     dm_o,
  output sva_pkg::sva_flags_t             flags_o
);

  logic [sva_pkg::REM_W-1:0] rem_sh;
  logic [sva_pkg::REM_W-1:0] trial;
  logic                      ge;
  logic                      valid_q;
  logic [sva_pkg::REM_W-1:0] rem_q, rem_d;
  logic [31:0]               root_q, root_d;
  logic [63:0]               n_q;
  logic [31:0]               dm_q;
  sva_pkg::sva_flags_t       flags_q;

  always_comb begin
    rem_sh = {rem_i[sva_pkg::REM_W-3:0], n_i[63-2*STEP -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem_sh >= trial;
    rem_d  = ge ? rem_sh - trial : rem_sh;
    root_d = {root_i[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      root_q  <= root_d;
      n_q     <= n_i;
      dm_q    <= dm_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign n_o     = n_q;
  assign dm_o    = dm_q;
  assign flags_o = flags_q;

endmodule

>>> hdl/sva_cordic_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC rotation cell; rotates towards y = 0 and
// accumulates the angle. Depends on sva_pkg.
module sva_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [sva_pkg::XY_W-1:0]   x_i,
  input  logic signed [sva_pkg::XY_W-1:0]   y_i,
  input  logic signed [sva_pkg::Z_W-1:0]    z_i,
  input  sva_pkg::sva_flags_t               flags_i,
  output logic                              valid_o,
  output logic signed [sva_pkg::XY_W-1:0]   x_o,
  output logic signed [sva_pkg::XY_W-1:0]   y_o,
  output logic signed [sva_pkg::Z_W-1:0]    z_o,
  output sva_pkg::sva_flags_t               flags_o
);

  logic signed [sva_pkg::XY_W-1:0] xs, ys, x_d, y_d;
  logic signed [sva_pkg::Z_W-1:0]  at, z_d;
  logic                            valid_q;
  logic signed [sva_pkg::XY_W-1:0] x_q, y_q;
  logic signed [sva_pkg::Z_W-1:0]  z_q;
  sva_pkg::sva_flags_t             flags_q;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    at = $signed({{(sva_pkg::Z_W-24){1'b0}}, sva_pkg::ATAN_Q24[STEP]});
    if (!y_i[sva_pkg::XY_W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + at;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule
